// ===== hdl/sensor_ack_frame_checker_top_assert.svh =====
// assertion macros for the reply frame checker
`ifndef SENSOR_ACK_FRAME_CHECKER_TOP_ASSERT_SVH
`define SENSOR_ACK_FRAME_CHECKER_TOP_ASSERT_SVH

// same-cycle implication
`define SAFC_ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("safc check failed");

// next-cycle implication
`define SAFC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("safc check failed");

`endif

// ===== hdl/safc_pkg.sv =====
package safc_pkg;

	localparam int HDR_DEPTH = 7;
	localparam int LEN_W     = 5;

	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'hA001;
	localparam logic [7:0]  CRC_PATCH = 8'hA5;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_NET  = 2'd1;
	localparam logic [1:0] ST_SLV  = 2'd2;
	localparam logic [1:0] ST_CRC  = 2'd3;

	localparam logic [2:0] REG_NET_ADDR  = 3'd0;
	localparam logic [2:0] REG_READ_OP   = 3'd1;
	localparam logic [2:0] REG_TEMP_MASK = 3'd2;
	localparam logic [2:0] REG_HUM_MASK  = 3'd3;
	localparam logic [2:0] REG_HB_MASK   = 3'd4;

	typedef struct packed {
		logic [7:0]       hdr0;
		logic [7:0]       hdr1;
		logic [7:0]       hdr3;
		logic [7:0]       hdr4;
		logic [7:0]       hdr6;
		logic [7:0]       slave;
		logic [7:0]       op;
		logic [7:0]       param;
		logic [LEN_W-1:0] lnz;
		logic [15:0]      crc;
		logic [15:0]      check;
	} safc_frame_t;

	typedef struct packed {
		logic full;
		logic empty;
	} safc_qstat_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	function automatic logic single_bit(input logic [7:0] m);
		return (m != 8'h00) && ((m & (m - 8'h01)) == 8'h00);
	endfunction

endpackage

// ===== hdl/safc_front.sv =====
module safc_front import safc_pkg::*; #(
	parameter int MAX_FRAME_BYTES = 9
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic [7:0]  expected_slave,
	input  logic [7:0]  request_op,
	input  logic [7:0]  request_param,
	output logic        push,
	output safc_frame_t frame
);

	localparam int PW = $clog2(MAX_FRAME_BYTES + 1);
	localparam logic [PW-1:0] MAX_POS = PW'(MAX_FRAME_BYTES);

	logic [PW-1:0] pos_q, pos_n;
	logic [15:0]   crc_q, crc_n;
	logic [15:0]   crc1_q, crc1_n;
	logic [7:0]    prev_q, prev_n;
	logic [15:0]   crc_end_q, crc_end_n;
	logic [15:0]   check_q, check_n;
	logic [PW-1:0] lnz_q, lnz_n;
	logic [7:0]    hdr_q [HDR_DEPTH];
	logic [7:0]    hdr_n [HDR_DEPTH];
	logic [23:0]   req_q, req_n;
	logic [15:0]   crc_adj;

	always_comb begin
		pos_n     = pos_q;
		crc_n     = crc_q;
		crc1_n    = crc1_q;
		prev_n    = prev_q;
		crc_end_n = crc_end_q;
		check_n   = check_q;
		lnz_n     = lnz_q;
		hdr_n     = hdr_q;
		req_n     = req_q;
		if (pos_q == '0) begin
			req_n = {expected_slave, request_op, request_param};
		end
		if (pos_q < MAX_POS) begin
			for (int k = 0; k < HDR_DEPTH; k++) begin
				if (pos_q == PW'(k)) begin
					hdr_n[k] = data_byte;
				end
			end
			if (data_byte != 8'h00) begin
				lnz_n     = pos_q + PW'(1);
				crc_end_n = crc1_q;
				check_n   = {prev_q, data_byte};
			end
			crc1_n = crc_q;
			crc_n  = crc_byte(crc_q, data_byte);
			prev_n = data_byte;
			pos_n  = pos_q + PW'(1);
		end
	end

	// low byte zero gets the patch pattern
	assign crc_adj = (crc_end_n[7:0] == 8'h00) ? {crc_end_n[15:8], CRC_PATCH} : crc_end_n;

	assign push = accept && last_byte;

	always_comb begin
		frame.hdr0  = hdr_n[0];
		frame.hdr1  = hdr_n[1];
		frame.hdr3  = hdr_n[3];
		frame.hdr4  = hdr_n[4];
		frame.hdr6  = hdr_n[6];
		frame.slave = req_n[23:16];
		frame.op    = req_n[15:8];
		frame.param = req_n[7:0];
		frame.lnz   = LEN_W'(lnz_n);
		frame.crc   = crc_adj;
		frame.check = check_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			crc_q     <= CRC_INIT;
			crc1_q    <= CRC_INIT;
			prev_q    <= '0;
			crc_end_q <= CRC_INIT;
			check_q   <= '0;
			lnz_q     <= '0;
			req_q     <= '0;
			for (int k = 0; k < HDR_DEPTH; k++) begin
				hdr_q[k] <= '0;
			end
		end else if (accept) begin
			if (last_byte) begin
				pos_q     <= '0;
				crc_q     <= CRC_INIT;
				crc1_q    <= CRC_INIT;
				prev_q    <= '0;
				crc_end_q <= CRC_INIT;
				check_q   <= '0;
				lnz_q     <= '0;
				req_q     <= '0;
				for (int k = 0; k < HDR_DEPTH; k++) begin
					hdr_q[k] <= '0;
				end
			end else begin
				pos_q     <= pos_n;
				crc_q     <= crc_n;
				crc1_q    <= crc1_n;
				prev_q    <= prev_n;
				crc_end_q <= crc_end_n;
				check_q   <= check_n;
				lnz_q     <= lnz_n;
				req_q     <= req_n;
				hdr_q     <= hdr_n;
			end
		end
	end

endmodule

// ===== hdl/safc_fifo.sv =====
module safc_fifo import safc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  safc_frame_t wr_data,
	input  logic        pop,
	output safc_frame_t rd_data,
	output safc_qstat_t stat
);

	safc_frame_t mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	assign stat.full  = (count_q == 2'd2);
	assign stat.empty = (count_q == 2'd0);
	assign rd_data    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ===== hdl/safc_back.sv =====
module safc_back import safc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  safc_frame_t frame,
	input  logic        avail,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata
);

	logic [7:0]  net_addr_q, read_op_q, temp_mask_q, hum_mask_q, hb_mask_q;
	logic        out_valid_q;
	logic [47:0] out_data_s1;
	logic [1:0]  status;
	logic [3:0]  len4;
	logic        ok, tv, hv, bv;

	always_comb begin
		len4 = (frame.lnz == '0) ? 4'd1 : frame.lnz[3:0];
		priority if (frame.hdr0 != net_addr_q) begin
			status = ST_NET;
		end else if (frame.hdr1 != frame.slave) begin
			status = ST_SLV;
		end else if (frame.lnz < LEN_W'(2) || frame.crc != frame.check) begin
			status = ST_CRC;
		end else begin
			status = ST_OK;
		end
		ok = (status == ST_OK) && (frame.op == read_op_q);
		tv = ok && single_bit(temp_mask_q) && ((frame.param & temp_mask_q) != 8'h00);
		hv = ok && single_bit(hum_mask_q) && ((frame.param & hum_mask_q) != 8'h00);
		bv = ok && single_bit(hb_mask_q) && ((frame.param & hb_mask_q) != 8'h00);
	end

	assign pop      = avail && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_s1;

	always_ff @(posedge clk) begin
		if (pop) begin
			out_data_s1 <= {7'd0,
				bv, bv ? frame.hdr6 : 8'h00,
				hv, hv ? frame.hdr4 : 8'h00,
				tv, tv ? frame.hdr3 : 8'h00,
				frame.slave, len4, status};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			net_addr_q  <= 8'd1;
			read_op_q   <= 8'd3;
			temp_mask_q <= 8'd1;
			hum_mask_q  <= 8'd2;
			hb_mask_q   <= 8'd4;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_NET_ADDR:  net_addr_q  <= cfg_data;
				REG_READ_OP:   read_op_q   <= cfg_data;
				REG_TEMP_MASK: temp_mask_q <= cfg_data;
				REG_HUM_MASK:  hum_mask_q  <= cfg_data;
				REG_HB_MASK:   hb_mask_q   <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ===== hdl/sensor_ack_frame_checker_top.sv =====
// reply frame checker: one byte per cycle in while the queue is not full, one result per frame out
// path: the last byte pushes the frame into the queue, and the output register takes it on pop
// throughput: one byte per cycle, limited by the two-entry frame queue when the output stalls
// reset: async active low; clears frame state, queue, output valid and loads register defaults
module sensor_ack_frame_checker_top import safc_pkg::*; #(
	parameter int MAX_FRAME_BYTES = 9
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // data_byte, expected_slave, request_op, request_param
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // frame_status, frame_length, slave_index,
	                              // temperature_value, temperature_valid, humidity_value,
	                              // humidity_valid, heartbeat_value, heartbeat_valid, zero pad
);

	`include "sensor_ack_frame_checker_top_assert.svh"

	logic        accept;
	logic        push;
	logic        pop;
	safc_frame_t front_frame;
	safc_frame_t head_frame;
	safc_qstat_t q_stat;

	assign s_tready = !q_stat.full;
	assign accept   = s_tvalid && s_tready;

	safc_front #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.data_byte      (s_tdata[7:0]),
		.last_byte      (s_tlast),
		.expected_slave (s_tdata[15:8]),
		.request_op     (s_tdata[23:16]),
		.request_param  (s_tdata[31:24]),
		.push           (push),
		.frame          (front_frame)
	);

	safc_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (front_frame),
		.pop     (pop),
		.rd_data (head_frame),
		.stat    (q_stat)
	);

	safc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.frame     (head_frame),
		.avail     (!q_stat.empty),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	`SAFC_ASSERT_IMPLIES(a_no_push_full, push, !q_stat.full)
	`SAFC_ASSERT_IMPLIES(a_temp_needs_ok, m_tvalid && m_tdata[22], m_tdata[1:0] == ST_OK)
	`SAFC_ASSERT_NEXT(a_pop_shows, pop, m_tvalid)

endmodule

// ===== tb/sensor_ack_frame_checker_top_test.sv =====
module sensor_ack_frame_checker_top_test import safc_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAME_MAX = 9;
	localparam logic [2:0] REG_SPARE = 3'd7;

	typedef struct packed {
		logic [7:0] param;
		logic [7:0] op;
		logic [7:0] slave;
		logic [7:0] data;
	} reply_byte_t;

	typedef struct packed {
		logic        last;
		reply_byte_t word;
	} reply_item_t;

	typedef struct packed {
		logic [6:0] pad;
		logic       hb_valid;
		logic [7:0] hb;
		logic       hum_valid;
		logic [7:0] hum;
		logic       temp_valid;
		logic [7:0] temp;
		logic [7:0] slave;
		logic [3:0] length;
		logic [1:0] status;
	} reply_check_t;

	typedef logic [7:0] byte_list_t[$];

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;

	reply_item_t  pending_q[$];
	reply_check_t expected_q[$];

	int   fail_count = 0;
	int   results_seen = 0;
	int   items_sent = 0;
	int   settings_used = 0;
	logic idle_on = 1'b1;
	int   src_gap = 0;
	int   sink_gap = 0;
	reply_item_t next_item;

	logic [7:0] reg_shadow[5] = '{8'd1, 8'd3, 8'd1, 8'd2, 8'd4};
	logic [7:0] cfg_model[5] = '{8'd1, 8'd3, 8'd1, 8'd2, 8'd4};

	// per-frame state of the predictor
	int          frame_pos = 0;
	int          nz_len = 0;
	logic [15:0] crc_run = CRC_INIT;
	logic [15:0] crc_back = CRC_INIT;
	logic [15:0] crc_at_nz = CRC_INIT;
	logic [15:0] check_word = '0;
	logic [7:0]  prev_byte = '0;
	logic [7:0]  req_slave = '0;
	logic [7:0]  req_op = '0;
	logic [7:0]  req_param = '0;
	logic [7:0]  hdr[HDR_DEPTH] = '{default: 8'h00};

	sensor_ack_frame_checker_top #(.MAX_FRAME_BYTES(FRAME_MAX)) DUT (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic [15:0] crc16_update(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		repeat (8) r = r[0] ? ({1'b0, r[15:1]} ^ CRC_POLY) : {1'b0, r[15:1]};
		return r;
	endfunction

	function automatic logic [15:0] frame_crc(input byte_list_t b);
		logic [15:0] c;
		c = CRC_INIT;
		foreach (b[k]) c = crc16_update(c, b[k]);
		return c;
	endfunction

	// payload followed by its crc, high byte first, low byte patched when zero
	function automatic byte_list_t sealed(input byte_list_t b);
		logic [15:0] c;
		c = frame_crc(b);
		if (c[7:0] == 8'h00)
			c = c | {8'h00, CRC_PATCH};
		b.push_back(c[15:8]);
		b.push_back(c[7:0]);
		return b;
	endfunction

	function automatic logic mask_hit(input logic [7:0] param, input logic [7:0] mask);
		return ($countones(mask) == 1) && ((param & mask) != 8'h00);
	endfunction

	function automatic logic [7:0] any_byte();
		return ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom);
	endfunction

	function automatic logic [7:0] flip_bits();
		return 8'($urandom_range(1, 255));
	endfunction

	function automatic logic [7:0] pick_mask();
		return ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'(1 << $urandom_range(0, 7));
	endfunction

	task automatic absorb_byte(input reply_byte_t w, input logic last);
		reply_check_t r;
		logic [15:0]  crc;
		int           len;
		logic         ok;
		if (frame_pos == 0) begin
			req_slave = w.slave;
			req_op = w.op;
			req_param = w.param;
		end
		if (frame_pos < FRAME_MAX) begin
			if (frame_pos < HDR_DEPTH)
				hdr[frame_pos] = w.data;
			if (w.data != 8'h00) begin
				nz_len = frame_pos + 1;
				crc_at_nz = crc_back;
				check_word = {prev_byte, w.data};
			end
			crc_back = crc_run;
			crc_run = crc16_update(crc_run, w.data);
			prev_byte = w.data;
			frame_pos++;
		end
		if (last) begin
			len = (nz_len != 0) ? nz_len : 1;
			crc = crc_at_nz;
			if (crc[7:0] == 8'h00)
				crc = crc | {8'h00, CRC_PATCH};
			r = '0;
			if (hdr[0] != cfg_model[REG_NET_ADDR])
				r.status = ST_NET;
			else if (hdr[1] != req_slave)
				r.status = ST_SLV;
			else if (len < 2 || crc != check_word)
				r.status = ST_CRC;
			else
				r.status = ST_OK;
			r.length = 4'(len);
			r.slave = req_slave;
			ok = (r.status == ST_OK) && (req_op == cfg_model[REG_READ_OP]);
			if (ok && mask_hit(req_param, cfg_model[REG_TEMP_MASK])) begin
				r.temp_valid = 1'b1;
				r.temp = hdr[3];
			end
			if (ok && mask_hit(req_param, cfg_model[REG_HUM_MASK])) begin
				r.hum_valid = 1'b1;
				r.hum = hdr[4];
			end
			if (ok && mask_hit(req_param, cfg_model[REG_HB_MASK])) begin
				r.hb_valid = 1'b1;
				r.hb = hdr[6];
			end
			expected_q.push_back(r);
			frame_pos = 0;
			nz_len = 0;
			crc_run = CRC_INIT;
			crc_back = CRC_INIT;
			crc_at_nz = CRC_INIT;
			check_word = '0;
			prev_byte = '0;
			req_slave = '0;
			req_op = '0;
			req_param = '0;
			foreach (hdr[k]) hdr[k] = 8'h00;
		end
	endtask

	function automatic void compare_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			fail_count++;
		end
	endfunction

	task automatic check_result(input reply_check_t got);
		reply_check_t want;
		if (expected_q.size() == 0) begin
			$display("%0t: result with nothing expected, expected none got %h", $time, got);
			fail_count++;
		end else begin
			want = expected_q.pop_front();
			results_seen++;
			compare_field("frame_status", want.status, got.status);
			compare_field("frame_length", want.length, got.length);
			compare_field("slave_index", want.slave, got.slave);
			compare_field("temperature_value", want.temp, got.temp);
			compare_field("temperature_valid", want.temp_valid, got.temp_valid);
			compare_field("humidity_value", want.hum, got.hum);
			compare_field("humidity_valid", want.hum_valid, got.hum_valid);
			compare_field("heartbeat_value", want.hb, got.hb);
			compare_field("heartbeat_valid", want.hb_valid, got.hb_valid);
			compare_field("pad", want.pad, got.pad);
		end
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n && (!s_tvalid || s_tready)) begin
			if (src_gap > 0) begin
				s_tvalid <= 1'b0;
				src_gap--;
			end else if (pending_q.size() != 0) begin
				next_item = pending_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= next_item.word;
				s_tlast <= next_item.last;
				items_sent++;
				if (idle_on && $urandom_range(0, 5) == 0)
					src_gap = $urandom_range(1, 11);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result sink stalls
	always @(posedge clk) begin
		if (sink_gap > 0) begin
			m_tready <= 1'b0;
			sink_gap--;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			m_tready <= 1'b0;
			sink_gap = $urandom_range(0, 10);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wr_en && cfg_index <= REG_HB_MASK)
				cfg_model[cfg_index] = cfg_data;
			if (m_tvalid && m_tready)
				check_result(m_tdata);
			if (s_tvalid && s_tready)
				absorb_byte(s_tdata, s_tlast);
		end
	end

	task automatic send_reply(input byte_list_t b, input logic [7:0] slave,
			input logic [7:0] op, input logic [7:0] param);
		reply_item_t it;
		foreach (b[k]) begin
			it.last = (k == b.size() - 1);
			it.word.data = b[k];
			if (k == 0) begin
				it.word.slave = slave;
				it.word.op = op;
				it.word.param = param;
			end else begin
				it.word.slave = 8'($urandom);
				it.word.op = 8'($urandom);
				it.word.param = 8'($urandom);
			end
			pending_q.push_back(it);
		end
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx <= REG_HB_MASK)
			reg_shadow[idx] = val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic drain();
		while (pending_q.size() != 0 || s_tvalid || expected_q.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		byte_list_t  b;
		int          kind;
		int          n;
		int          n_items;
		logic [7:0]  slave;
		logic [7:0]  op;
		logic [7:0]  net_v;
		logic [7:0]  op_v;
		logic [7:0]  tm;
		logic [7:0]  hm;
		logic [7:0]  bm;
		logic [15:0] c;
		bit          found;
		logic [7:0]  hit_s;
		logic [7:0]  hit_v;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		@(negedge clk);

		// directed frames at reset register values
		b = {8'h01, 8'h42, 8'h03, 8'h19, 8'h37, 8'h00, 8'hFE};
		send_reply(sealed(b), 8'h42, 8'h03, 8'hFF);

		// crc whose low byte is zero, short frame so unsent bytes read as zero
		found = 1'b0;
		hit_s = '0;
		hit_v = '0;
		for (int s = 0; s < 256 && !found; s++) begin
			for (int v = 0; v < 256 && !found; v++) begin
				b = {8'h01, 8'(s), 8'(v)};
				c = frame_crc(b);
				if (c[7:0] == 8'h00) begin
					found = 1'b1;
					hit_s = 8'(s);
					hit_v = 8'(v);
				end
			end
		end
		b = {8'h01, hit_s, hit_v};
		send_reply(sealed(b), hit_s, 8'h03, 8'h07);

		b = {8'h80, 8'h11, 8'h22};
		send_reply(b, 8'h11, 8'h03, 8'h01);
		b = {8'h01, 8'h11};
		send_reply(sealed(b), 8'h12, 8'h03, 8'h01);
		b = {8'h01};
		send_reply(b, 8'h00, 8'h03, 8'h01);
		b = {8'h00, 8'h00};
		send_reply(b, 8'h00, 8'h00, 8'h00);

		for (int phase = 1; phase <= 6; phase++) begin
			drain();
			case (phase)
				1: begin
					net_v = 8'h00;
					op_v = 8'h00;
					tm = 8'h80;
					hm = 8'h40;
					bm = 8'h01;
				end
				2: begin
					net_v = 8'hFF;
					op_v = 8'hFF;
					tm = 8'h00;
					hm = 8'h03;
					bm = 8'hFF;
				end
				default: begin
					net_v = 8'($urandom);
					op_v = 8'($urandom);
					tm = pick_mask();
					hm = pick_mask();
					bm = pick_mask();
				end
			endcase
			write_reg(REG_NET_ADDR, net_v);
			write_reg(REG_READ_OP, op_v);
			write_reg(REG_TEMP_MASK, tm);
			write_reg(REG_HUM_MASK, hm);
			write_reg(REG_HB_MASK, bm);
			if (phase == 2)
				write_reg(REG_SPARE, 8'($urandom));
			settings_used++;
			idle_on = (phase != 4) && (phase != 6);
			@(negedge clk);

			n_items = 0;
			while (n_items < 165) begin
				slave = 8'($urandom);
				op = ($urandom_range(0, 3) != 0) ? reg_shadow[REG_READ_OP] : 8'($urandom);
				kind = $urandom_range(0, 99);
				if (kind >= 92) begin
					// noise
					b = {};
					n = $urandom_range(1, 12);
					repeat (n) b.push_back(any_byte());
					if ($urandom_range(0, 1) == 1)
						b[0] = reg_shadow[REG_NET_ADDR];
					if (n > 1 && $urandom_range(0, 1) == 1)
						b[1] = slave;
				end else begin
					b = {reg_shadow[REG_NET_ADDR], slave};
					n = $urandom_range(0, 5);
					repeat (n) b.push_back(any_byte());
					b = sealed(b);
					if (kind >= 85) begin
						repeat ($urandom_range(1, 8)) b.push_back(any_byte());
					end else if (kind >= 78) begin
						n = $urandom_range(0, b.size() - 1);
						b[n] = b[n] ^ flip_bits();
					end else if (kind >= 72) begin
						slave = slave ^ flip_bits();
					end else if (kind >= 66) begin
						b[0] = b[0] ^ flip_bits();
					end else if ($urandom_range(0, 5) == 0) begin
						while (b.size() < 11) b.push_back(8'h00);
					end
				end
				send_reply(b, slave, op, 8'($urandom));
				n_items += b.size();
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (expected_q.size() != 0) begin
			$display("%0t: expected %0d more results, got none", $time, expected_q.size());
			fail_count++;
		end
		$display("covered %0d reply frames (%0d bytes) under %0d register settings",
			results_seen, items_sent, settings_used + 1);
		$display("frames were good, corrupted, truncated, overlong and random, with stalls");
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#3000000;
		$display("timeout: checker did not finish");
		$display("Simulation FAILED");
		$finish;
	end

endmodule
